### sv/u8d_pkg.sv
package u8d_pkg;

   localparam int unsigned BYTE_W = 8;
   localparam int unsigned CP_W   = 21;
   localparam int unsigned CNT_W  = 2;

   localparam logic [CP_W-1:0] CP_REPLACEMENT = 21'h00FFFD;
   localparam logic [CP_W-1:0] CP_MIN_2B      = 21'h000080;
   localparam logic [CP_W-1:0] CP_MIN_3B      = 21'h000800;
   localparam logic [CP_W-1:0] CP_MIN_4B      = 21'h010000;
   localparam logic [CP_W-1:0] CP_SURR_LO     = 21'h00D800;
   localparam logic [CP_W-1:0] CP_SURR_END    = 21'h00E000;
   localparam logic [CP_W-1:0] CP_LIMIT       = 21'h110000;

   // continuation bytes an open sequence needs in all
   localparam logic [CNT_W-1:0] SEQ_NONE = 2'd0;
   localparam logic [CNT_W-1:0] SEQ_2B   = 2'd1;
   localparam logic [CNT_W-1:0] SEQ_3B   = 2'd2;
   localparam logic [CNT_W-1:0] SEQ_4B   = 2'd3;

   typedef struct packed {
      logic            emit;
      logic [CP_W-1:0] code_point;
      logic            was_error;
   } dec_result_type;

endpackage

### sv/u8d_decode.sv
module u8d_decode (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         fire,
   input  logic [u8d_pkg::BYTE_W-1:0]   byte_in,
   output u8d_pkg::dec_result_type      result
);
   import u8d_pkg::*;

   logic [CNT_W-1:0] pending_ff, pending_in;
   logic [CNT_W-1:0] seq_len_ff, seq_len_in;
   logic [CP_W-1:0]  partial_ff, partial_in;
   logic [CP_W-1:0]  shifted;
   logic [CNT_W-1:0] pending_dec;
   logic             value_ok;

   assign shifted     = {partial_ff[CP_W-7:0], byte_in[5:0]};
   assign pending_dec = pending_ff - 2'd1;

   always_comb begin
      unique case (seq_len_ff)
         SEQ_2B:  value_ok = (shifted >= CP_MIN_2B);
         SEQ_3B:  value_ok = (shifted >= CP_MIN_3B) &&
                             ((shifted < CP_SURR_LO) || (shifted >= CP_SURR_END));
         default: value_ok = (shifted >= CP_MIN_4B) && (shifted < CP_LIMIT);
      endcase
   end

   always_comb begin
      pending_in        = pending_ff;
      seq_len_in        = seq_len_ff;
      partial_in        = partial_ff;
      result.emit       = 1'b0;
      result.code_point = CP_REPLACEMENT;
      result.was_error  = 1'b1;
      if (pending_ff != SEQ_NONE) begin
         if (byte_in[7:6] != 2'b10) begin
            // broken sequence, byte swallowed
            result.emit = 1'b1;
            pending_in  = SEQ_NONE;
            seq_len_in  = SEQ_NONE;
            partial_in  = '0;
         end else if (pending_dec != SEQ_NONE) begin
            pending_in = pending_dec;
            partial_in = shifted;
         end else begin
            result.emit = 1'b1;
            pending_in  = SEQ_NONE;
            seq_len_in  = SEQ_NONE;
            partial_in  = '0;
            if (value_ok) begin
               result.code_point = shifted;
               result.was_error  = 1'b0;
            end
         end
      end else if (!byte_in[7]) begin
         result.emit       = 1'b1;
         result.code_point = {{(CP_W-BYTE_W){1'b0}}, byte_in};
         result.was_error  = 1'b0;
      end else if (byte_in[7:5] == 3'b110) begin
         seq_len_in = SEQ_2B;
         pending_in = SEQ_2B;
         partial_in = {{(CP_W-5){1'b0}}, byte_in[4:0]};
      end else if (byte_in[7:4] == 4'b1110) begin
         seq_len_in = SEQ_3B;
         pending_in = SEQ_3B;
         partial_in = {{(CP_W-4){1'b0}}, byte_in[3:0]};
      end else if (byte_in[7:3] == 5'b11110) begin
         seq_len_in = SEQ_4B;
         pending_in = SEQ_4B;
         partial_in = {{(CP_W-3){1'b0}}, byte_in[2:0]};
      end else begin
         // stray continuation or lead of f8 and above
         result.emit = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pending_ff <= SEQ_NONE;
         seq_len_ff <= SEQ_NONE;
         partial_ff <= '0;
      end else if (fire) begin
         pending_ff <= pending_in;
         seq_len_ff <= seq_len_in;
         partial_ff <= partial_in;
      end
   end

endmodule

### sv/utf8_stream_decoder_top.sv
// channel | direction | handshake           | payload
// req     | in        | req_valid/req_stall | req_byte_in[7:0]
// rsp     | out       | rsp_valid/rsp_stall | rsp_code_point[20:0], rsp_was_error
//
// one byte accepted per cycle unless req_stall is high
// byte register feeds the decoder, the decoder feeds the result register
// reset is synchronous, clears both valid flags and the decoder state
// rsp_stall backs up into req_stall only while a result waits and the held byte
// would give another one; bytes that only extend a sequence keep flowing
module utf8_stream_decoder_top (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic [u8d_pkg::BYTE_W-1:0]    req_byte_in,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [u8d_pkg::CP_W-1:0]      rsp_code_point,
   output logic                          rsp_was_error
);
   import u8d_pkg::*;

   // input register
   logic              in_valid_ff, in_valid_in;
   logic [BYTE_W-1:0] in_byte_ff;

   // result register
   logic              out_valid_ff, out_valid_in;
   logic [CP_W-1:0]   out_cp_ff;
   logic              out_err_ff;

   dec_result_type    dec;
   logic              out_free;
   logic              advance;

   u8d_decode u_decode (
      .clock   (clock),
      .reset   (reset),
      .fire    (advance),
      .byte_in (in_byte_ff),
      .result  (dec)
   );

   // result slot is free when empty or being drained this cycle
   assign out_free  = !out_valid_ff || !rsp_stall;
   // held byte moves on unless it makes a result with nowhere to go
   assign advance   = in_valid_ff && (!dec.emit || out_free);
   assign req_stall = in_valid_ff && !advance;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (!req_stall) begin
         in_valid_in = req_valid;
      end
   end

   always_comb begin
      out_valid_in = out_valid_ff;
      if (advance && dec.emit) begin
         out_valid_in = 1'b1;
      end else if (out_free) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // payload, no reset needed
   always_ff @(posedge clock) begin
      if (req_valid && !req_stall) begin
         in_byte_ff <= req_byte_in;
      end
      if (advance && dec.emit) begin
         out_cp_ff  <= dec.code_point;
         out_err_ff <= dec.was_error;
      end
   end

   assign rsp_valid      = out_valid_ff;
   assign rsp_code_point = out_cp_ff;
   assign rsp_was_error  = out_err_ff;

endmodule

### sv/u8d_checker.sv
module u8d_checker (
   input logic                          clock,
   input logic                          reset,
   input logic                          req_stall,
   input logic                          rsp_valid,
   input logic                          rsp_stall,
   input logic [u8d_pkg::CP_W-1:0]      rsp_code_point,
   input logic                          rsp_was_error
);
   import u8d_pkg::*;

   // a stalled result beat holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_code_point)
                                 && $stable(rsp_was_error))
      else $error("result beat changed under stall");

   // error beats always carry the replacement character
   a_err_cp: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_was_error |-> rsp_code_point == CP_REPLACEMENT)
      else $error("error beat without replacement code point");

   // clean beats are scalar values
   a_scalar: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_was_error |-> (rsp_code_point < CP_LIMIT) &&
         ((rsp_code_point < CP_SURR_LO) || (rsp_code_point >= CP_SURR_END)))
      else $error("clean beat outside scalar range");

   // nothing leaves right after reset
   a_reset_quiet: assert property (@(posedge clock)
      $past(reset) && !reset |-> !rsp_valid && !req_stall)
      else $error("activity straight after reset");

endmodule

bind utf8_stream_decoder_top u8d_checker u_u8d_checker (
   .clock          (clock),
   .reset          (reset),
   .req_stall      (req_stall),
   .rsp_valid      (rsp_valid),
   .rsp_stall      (rsp_stall),
   .rsp_code_point (rsp_code_point),
   .rsp_was_error  (rsp_was_error)
);

### dv/tb_utf8_stream_decoder_top.sv
`timescale 1ns / 1ps

module tb_utf8_stream_decoder_top;
   import u8d_pkg::*;

   // a code point the decoder must produce, oldest first in the queue
   typedef struct packed {
      logic            was_error;
      logic [CP_W-1:0] code_point;
   } decoded_cp_type;

   // one byte waiting to be offered; settle holds it back until the decoder has drained
   typedef struct packed {
      logic              settle;
      logic [BYTE_W-1:0] value;
   } text_byte_type;

   localparam int unsigned CYCLE_LIMIT = 400000;
   localparam int unsigned TAIL_CYCLES = 10;
   localparam int unsigned LONG_HOLD   = 80;
   localparam int unsigned MAX_SHOWN   = 10;

   logic              clock;
   logic              reset       = 1'b1;
   logic              req_valid   = 1'b0;
   logic              req_stall;
   logic [BYTE_W-1:0] req_byte_in = '0;
   logic              rsp_valid;
   logic              rsp_stall   = 1'b0;
   logic [CP_W-1:0]   rsp_code_point;
   logic              rsp_was_error;

   text_byte_type  text_q[$];
   decoded_cp_type cp_expect_q[$];

   // decoder state as seen by the checker
   logic [CNT_W-1:0] seq_pending = SEQ_NONE;
   logic [CNT_W-1:0] seq_total   = SEQ_NONE;
   logic [CP_W-1:0]  seq_value   = '0;

   // handshake seen at the last rising edge, read back at the falling edge
   logic req_taken = 1'b0;
   logic rsp_taken = 1'b0;

   int unsigned req_gap       = 0;
   int unsigned rsp_hold      = 0;
   int unsigned long_hold     = 0;
   bit          req_busy      = 1'b1;
   bit          rsp_busy      = 1'b1;
   int unsigned bytes_in      = 0;
   int unsigned cps_checked   = 0;
   int unsigned replacements  = 0;
   int unsigned mismatches    = 0;
   int unsigned cycle_count   = 0;

   utf8_stream_decoder_top dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_byte_in    (req_byte_in),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_code_point (rsp_code_point),
      .rsp_was_error  (rsp_was_error)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // ---------------------------------------------------------------
   // prediction: step the decoder state by one accepted byte and
   // queue the code point it gives, if any
   // ---------------------------------------------------------------
   function automatic void expect_cp(input logic [CP_W-1:0] cp, input logic err);
      decoded_cp_type e;
      e.code_point = cp;
      e.was_error  = err;
      cp_expect_q.push_back(e);
   endfunction

   function automatic void close_seq();
      seq_pending = SEQ_NONE;
      seq_total   = SEQ_NONE;
      seq_value   = '0;
   endfunction

   function automatic void decode_byte(input logic [BYTE_W-1:0] b);
      logic [CNT_W-1:0] total;
      logic [CP_W-1:0]  v;
      logic             ok;
      if (seq_pending != SEQ_NONE) begin
         // anything but a continuation kills the open sequence and is swallowed
         if (b[7:6] != 2'b10) begin
            close_seq();
            expect_cp(CP_REPLACEMENT, 1'b1);
            return;
         end
         seq_value   = {seq_value[CP_W-7:0], b[5:0]};
         seq_pending = seq_pending - 1'b1;
         if (seq_pending != SEQ_NONE)
            return;
         total = seq_total;
         v     = seq_value;
         close_seq();
         // overlong, surrogate and out-of-range values all become replacements
         case (total)
            SEQ_2B:  ok = (v >= CP_MIN_2B);
            SEQ_3B:  ok = (v >= CP_MIN_3B) && ((v < CP_SURR_LO) || (v >= CP_SURR_END));
            default: ok = (v >= CP_MIN_4B) && (v < CP_LIMIT);
         endcase
         if (ok)
            expect_cp(v, 1'b0);
         else
            expect_cp(CP_REPLACEMENT, 1'b1);
      end else if (!b[7]) begin
         expect_cp({{(CP_W-BYTE_W){1'b0}}, b}, 1'b0);
      end else if (b[7:5] == 3'b110) begin
         seq_total = SEQ_2B;
         seq_value = {{(CP_W-5){1'b0}}, b[4:0]};
      end else if (b[7:4] == 4'b1110) begin
         seq_total = SEQ_3B;
         seq_value = {{(CP_W-4){1'b0}}, b[3:0]};
      end else if (b[7:3] == 5'b11110) begin
         seq_total = SEQ_4B;
         seq_value = {{(CP_W-3){1'b0}}, b[2:0]};
      end else begin
         // stray continuation or an F8..FF lead
         expect_cp(CP_REPLACEMENT, 1'b1);
      end
      seq_pending = seq_total;
   endfunction

   // ---------------------------------------------------------------
   // stimulus helpers
   // ---------------------------------------------------------------
   function automatic void queue_byte(input logic [BYTE_W-1:0] b, input logic settle = 1'b0);
      text_byte_type t;
      t.settle = settle;
      t.value  = b;
      text_q.push_back(t);
   endfunction

   // n-byte encoding of any payload, first byte in the top lane; overlong
   // and out-of-range forms come out as the raw bits say
   function automatic logic [31:0] utf8_bytes(input int n, input logic [CP_W-1:0] p);
      case (n)
         1:       return {1'b0, p[6:0], 24'h0};
         2:       return {3'b110, p[10:6], 2'b10, p[5:0], 16'h0};
         3:       return {4'b1110, p[15:12], 2'b10, p[11:6], 2'b10, p[5:0], 8'h0};
         default: return {5'b11110, p[20:18], 2'b10, p[17:12], 2'b10, p[11:6],
                          2'b10, p[5:0]};
      endcase
   endfunction

   function automatic void queue_seq(input logic [31:0] w, input int count);
      for (int i = 0; i < count; i++)
         queue_byte(w[31-8*i -: 8]);
   endfunction

   function automatic void queue_cp(input int n, input logic [CP_W-1:0] p);
      queue_seq(utf8_bytes(n, p), n);
   endfunction

   function automatic void queue_random_seq();
      logic [CP_W-1:0]   cp;
      logic [BYTE_W-1:0] bad;
      int                n;
      int                pick;
      pick = $urandom_range(0, 99);
      if (pick < 20) begin
         queue_cp(1, CP_W'($urandom_range(0, 'h7F)));
      end else if (pick < 40) begin
         queue_cp(2, CP_W'($urandom_range('h80, 'h7FF)));
      end else if (pick < 60) begin
         queue_cp(3, CP_W'($urandom_range('h800, 'hFFFF)));
      end else if (pick < 72) begin
         queue_cp(4, CP_W'($urandom_range('h10000, 'h10FFFF)));
      end else if (pick < 82) begin
         // raw payload bits: overlong and too-large forms turn up here
         n  = $urandom_range(2, 4);
         cp = CP_W'($urandom);
         queue_cp(n, cp);
      end else if (pick < 87) begin
         cp = CP_W'($urandom_range(CP_SURR_LO, CP_SURR_END - 1));
         queue_cp(3, cp);
      end else if (pick < 94) begin
         // sequence cut short by a byte that is not a continuation
         n  = $urandom_range(2, 4);
         cp = CP_W'($urandom);
         queue_seq(utf8_bytes(n, cp), $urandom_range(1, n - 1));
         do bad = BYTE_W'($urandom_range(0, 255)); while (bad[7:6] == 2'b10);
         queue_byte(bad);
      end else begin
         queue_byte(BYTE_W'($urandom_range(0, 255)));
      end
   endfunction

   // ---------------------------------------------------------------
   // driver: one byte per beat, random gap after each, held while stalled
   // ---------------------------------------------------------------
   always @(negedge clock) begin : drive_text
      text_byte_type nxt;
      if (reset) begin
         req_valid <= 1'b0;
      end else if (req_valid && !req_taken) begin
         // stalled: payload stays as it is
      end else if (req_gap != 0) begin
         req_gap--;
         req_valid <= 1'b0;
      end else if (text_q.size() != 0 && !(text_q[0].settle && cp_expect_q.size() != 0)) begin
         nxt = text_q.pop_front();
         req_valid   <= 1'b1;
         req_byte_in <= nxt.value;
         // flip now and then between bursty and back-to-back stretches
         if ($urandom_range(0, 31) == 0)
            req_busy = !req_busy;
         req_gap = req_busy ? $urandom_range(0, 8) : 0;
      end else begin
         req_valid <= 1'b0;
      end
   end

   // ---------------------------------------------------------------
   // receiver: random stall per code point, plus long hold-offs that
   // fill the pipe and push back on the byte side
   // ---------------------------------------------------------------
   always @(negedge clock) begin : drive_rsp_stall
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_taken) begin
            if ($urandom_range(0, 31) == 0)
               rsp_busy = !rsp_busy;
            rsp_hold = rsp_busy ? $urandom_range(0, 8) : 0;
            if (cps_checked == 300 || cps_checked == 900)
               long_hold = LONG_HOLD;
         end
         if (long_hold != 0) begin
            long_hold--;
            rsp_stall <= 1'b1;
         end else if (rsp_hold != 0) begin
            rsp_hold--;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   // ---------------------------------------------------------------
   // monitor: predict from accepted bytes first, then check the result
   // beat against the oldest expected code point
   // ---------------------------------------------------------------
   always @(posedge clock) begin : check_decode
      decoded_cp_type want;
      req_taken <= !reset && req_valid && !req_stall;
      rsp_taken <= !reset && rsp_valid && !rsp_stall;
      if (!reset) begin
         if (req_valid && !req_stall) begin
            decode_byte(req_byte_in);
            bytes_in++;
         end
         if (rsp_valid && !rsp_stall) begin
            cps_checked++;
            if (cp_expect_q.size() == 0) begin
               mismatches++;
               if (mismatches <= MAX_SHOWN)
                  $display("unexpected code point %06h err %0b", rsp_code_point, rsp_was_error);
            end else begin
               want = cp_expect_q.pop_front();
               if (want.was_error)
                  replacements++;
               if (rsp_code_point !== want.code_point || rsp_was_error !== want.was_error) begin
                  mismatches++;
                  if (mismatches <= MAX_SHOWN)
                     $display("code point %0d: expected %06h err %0b, got %06h err %0b",
                              cps_checked, want.code_point, want.was_error,
                              rsp_code_point, rsp_was_error);
               end
            end
         end
      end
   end

   // watchdog
   always @(posedge clock) begin : watchdog
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("utf8_stream_decoder_top: mismatch");
         $finish;
      end
   end

   // ---------------------------------------------------------------
   // directed bytes, then random text, then drain and report
   // ---------------------------------------------------------------
   initial begin
      // plain ascii extremes
      queue_byte(8'h00);
      queue_byte(8'h7F);
      // stray continuation, then leads that can never be valid
      queue_byte(8'h80);
      queue_byte(8'hF8);
      queue_byte(8'hFF);
      // well-formed two, three and four byte sequences
      queue_seq(32'hC2A9_0000, 2);
      queue_seq(32'hE282_AC00, 3);
      queue_seq(32'hF09F_9880, 4);
      // overlong two-byte form
      queue_seq(32'hC080_0000, 2);
      // surrogate half
      queue_seq(32'hEDA0_8000, 3);
      // just past the top of the code space
      queue_seq(32'hF490_8080, 4);
      // lead followed by ascii: the ascii byte is swallowed
      queue_seq(32'hC341_0000, 2);

      while (text_q.size() < 1225) begin
         queue_random_seq();
         // pause the byte side near the 400th and 800th queued byte until every code point has come back
         if (text_q.size() >= 400 && text_q.size() < 405)
            queue_byte(BYTE_W'($urandom_range(0, 'h7F)), 1'b1);
         if (text_q.size() >= 800 && text_q.size() < 805)
            queue_byte(BYTE_W'($urandom_range(0, 'h7F)), 1'b1);
      end

      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // every byte offered and taken, then every code point seen
      while (text_q.size() != 0 || req_valid)
         @(posedge clock);
      while (cp_expect_q.size() != 0)
         @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);

      $display("decoded %0d bytes into %0d code points, %0d of them replacements",
               bytes_in, cps_checked, replacements);
      $display("%0d code point mismatches in %0d cycles", mismatches, cycle_count);
      if (mismatches == 0 && cp_expect_q.size() == 0)
         $display("utf8_stream_decoder_top: match");
      else
         $display("utf8_stream_decoder_top: mismatch");
      $finish;
   end

endmodule
